// ----- src/call_frame_stack_engine_unit_macros.svh -----
// Assertion macros for the call-frame stack engine.
`ifndef CALL_FRAME_STACK_ENGINE_UNIT_MACROS_SVH
`define CALL_FRAME_STACK_ENGINE_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define CFSE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define CFSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cfse_pkg.sv -----
// Package for the call-frame stack engine: sizes, codes and states.
package cfse_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int MAX_LOCALS  = 63;

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int TOP_W   = ADDR_W + 1;
    localparam int CHK_W   = ((TOP_W > 7) ? TOP_W : 7) + 1;
    localparam int SRC_W   = ((ADDR_W > 32) ? ADDR_W : 32) + 2;

    localparam int WORD_W  = 32;
    localparam int PC_W    = 16;
    localparam int CALLS_W = 8;
    localparam int CMD_W   = 3;
    localparam int CNT_W   = 6;
    localparam int VAR_W   = 6;
    localparam int STAT_W  = 3;

    localparam logic [CALLS_W-1:0] CALLS_MAX = {CALLS_W{1'b1}};

    localparam int IN_BITS  = CMD_W + PC_W + CNT_W + VAR_W + WORD_W + WORD_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = PC_W + WORD_W + CALLS_W + STAT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INVOKE = 3'd0,
        CMD_RETURN = 3'd1,
        CMD_PUSH   = 3'd2,
        CMD_LOAD   = 3'd3,
        CMD_STORE  = 3'd4,
        CMD_INCR   = 3'd5,
        CMD_FETCH  = 3'd6
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_RANGE     = 3'd2,
        ST_NOCALL    = 3'd3,
        ST_UNDERFLOW = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_INV_FP,
        S_FILL,
        S_RET_FP,
        S_RET_PC,
        S_RET_END,
        S_COPY_TOP,
        S_SLOT_WR,
        S_TOP,
        S_OUT
    } state_t;

endpackage

// ----- src/cfse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cfse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/call_frame_stack_engine_unit.sv -----
// Call-frame stack engine: data stack, frame pointer, pc and call depth under one sequencer.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   one command with its operands
//   m_*      out  m_tvalid/m_tready   pc, top of stack, call depth, status
//
// Each command steps through states set by the single stack RAM port pair and its registered read;
// invoke writes one zeroed local per cycle.
// Reset clears the stack pointer, frame pointer, pc and call depth; the RAM is not cleared.
// A finished result waits in the output register; a new command is taken meanwhile and
// holds in its last step until the output register frees.
`include "call_frame_stack_engine_unit_macros.svh"

module call_frame_stack_engine_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // command, target_address, local_count, var_index, offset, value, zero pad
    input  logic [cfse_pkg::IN_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // program_counter, top_value, call_depth_out, status, zero pad
    output logic [cfse_pkg::OUT_W-1:0] m_tdata
);

    localparam int AW = cfse_pkg::ADDR_W;
    localparam int TW = cfse_pkg::TOP_W;
    localparam int CW = cfse_pkg::CHK_W;
    localparam int SW = cfse_pkg::SRC_W;
    localparam int WW = cfse_pkg::WORD_W;
    localparam int PW = cfse_pkg::PC_W;

    cfse_pkg::state_t state_reg, state_next;

    logic [TW-1:0]                top_reg, top_next;
    logic [AW-1:0]                fp_reg, fp_next;
    logic [PW-1:0]                pc_reg, pc_next;
    logic [cfse_pkg::CALLS_W-1:0] calls_reg, calls_next;

    logic [cfse_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [PW-1:0]                tgt_reg, tgt_next;
    logic [cfse_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [cfse_pkg::VAR_W-1:0]   var_reg, var_next;
    logic [WW-1:0]                off_reg, off_next;
    logic [WW-1:0]                val_reg, val_next;
    cfse_pkg::status_t            status_reg, status_next;
    logic [AW-1:0]                newfp_reg, newfp_next;
    logic [PW-1:0]                newpc_reg, newpc_next;

    logic                         out_valid_reg, out_valid_next;
    logic [PW-1:0]                out_pc_reg, out_pc_next;
    logic [WW-1:0]                out_top_reg, out_top_next;
    logic [cfse_pkg::CALLS_W-1:0] out_calls_reg, out_calls_next;
    logic [cfse_pkg::STAT_W-1:0]  out_status_reg, out_status_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [WW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [WW-1:0] rd_data;

    logic [CW-1:0]        top_x;
    logic [CW-1:0]        slot_x;
    logic [CW-1:0]        inv_sum;
    logic signed [SW-1:0] src_s;
    logic signed [SW-1:0] top_s;
    logic [WW-1:0]        sum_word;
    logic                 exec_err;

    cfse_ram #(
        .WIDTH (WW),
        .DEPTH (cfse_pkg::STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign top_x    = CW'(top_reg);
    assign slot_x   = CW'(fp_reg) + CW'(var_reg) + CW'(1);
    assign inv_sum  = top_x + CW'(2) + CW'(cnt_reg);
    assign src_s    = $signed(SW'(fp_reg)) + $signed({{(SW-WW){off_reg[WW-1]}}, off_reg});
    assign top_s    = $signed(SW'(top_reg));
    assign sum_word = rd_data + off_reg;

    assign s_tready = (state_reg == cfse_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(cfse_pkg::OUT_W - cfse_pkg::OUT_BITS){1'b0}},
                       out_status_reg, out_calls_reg, out_top_reg, out_pc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfse_pkg::S_IDLE;
            top_reg       <= '0;
            fp_reg        <= '0;
            pc_reg        <= '0;
            calls_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            fp_reg        <= fp_next;
            pc_reg        <= pc_next;
            calls_reg     <= calls_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        tgt_reg        <= tgt_next;
        cnt_reg        <= cnt_next;
        var_reg        <= var_next;
        off_reg        <= off_next;
        val_reg        <= val_next;
        status_reg     <= status_next;
        newfp_reg      <= newfp_next;
        newpc_reg      <= newpc_next;
        out_pc_reg     <= out_pc_next;
        out_top_reg    <= out_top_next;
        out_calls_reg  <= out_calls_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        fp_next         = fp_reg;
        pc_next         = pc_reg;
        calls_next      = calls_reg;
        cmd_next        = cmd_reg;
        tgt_next        = tgt_reg;
        cnt_next        = cnt_reg;
        var_next        = var_reg;
        off_next        = off_reg;
        val_next        = val_reg;
        status_next     = status_reg;
        newfp_next      = newfp_reg;
        newpc_next      = newpc_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_pc_next     = out_pc_reg;
        out_top_next    = out_top_reg;
        out_calls_next  = out_calls_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        exec_err        = 1'b0;

        case (state_reg)
            cfse_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tdata[2:0];
                    tgt_next   = s_tdata[18:3];
                    cnt_next   = s_tdata[24:19];
                    var_next   = s_tdata[30:25];
                    off_next   = s_tdata[62:31];
                    val_next   = s_tdata[94:63];
                    state_next = cfse_pkg::S_EXEC;
                end
            end

            cfse_pkg::S_EXEC:
            begin
                status_next = cfse_pkg::ST_OK;
                state_next  = cfse_pkg::S_TOP;
                case (cfse_pkg::cmd_t'(cmd_reg))
                    cfse_pkg::CMD_INVOKE:
                    begin
                        if (32'(cnt_reg) > 32'(cfse_pkg::MAX_LOCALS)
                            || calls_reg == cfse_pkg::CALLS_MAX
                            || inv_sum > CW'(cfse_pkg::STACK_DEPTH))
                        begin
                            status_next = cfse_pkg::ST_OVERFLOW;
                            exec_err    = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = top_reg[AW-1:0];
                            wr_data    = {{(WW-PW){1'b0}}, pc_reg + PW'(1)};
                            state_next = cfse_pkg::S_INV_FP;
                        end
                    end
                    cfse_pkg::CMD_RETURN:
                    begin
                        if (calls_reg == '0)
                        begin
                            status_next = cfse_pkg::ST_NOCALL;
                            exec_err    = 1'b1;
                        end
                        else if (fp_reg == '0 || top_reg <= TW'(fp_reg))
                        begin
                            status_next = cfse_pkg::ST_UNDERFLOW;
                            exec_err    = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = fp_reg;
                            state_next = cfse_pkg::S_RET_FP;
                        end
                    end
                    cfse_pkg::CMD_PUSH:
                    begin
                        if (top_reg >= TW'(cfse_pkg::STACK_DEPTH))
                        begin
                            status_next = cfse_pkg::ST_OVERFLOW;
                            exec_err    = 1'b1;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = top_reg[AW-1:0];
                            wr_data  = val_reg;
                            top_next = top_reg + TW'(1);
                            pc_next  = pc_reg + PW'(1);
                        end
                    end
                    cfse_pkg::CMD_LOAD:
                    begin
                        if (slot_x >= top_x)
                        begin
                            status_next = cfse_pkg::ST_RANGE;
                            exec_err    = 1'b1;
                        end
                        else if (top_reg >= TW'(cfse_pkg::STACK_DEPTH))
                        begin
                            status_next = cfse_pkg::ST_OVERFLOW;
                            exec_err    = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = slot_x[AW-1:0];
                            state_next = cfse_pkg::S_COPY_TOP;
                        end
                    end
                    cfse_pkg::CMD_STORE:
                    begin
                        if (top_reg == '0)
                        begin
                            status_next = cfse_pkg::ST_UNDERFLOW;
                            exec_err    = 1'b1;
                        end
                        else if (slot_x >= top_x - CW'(1))
                        begin
                            status_next = cfse_pkg::ST_RANGE;
                            exec_err    = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(top_reg - TW'(1));
                            state_next = cfse_pkg::S_SLOT_WR;
                        end
                    end
                    cfse_pkg::CMD_INCR:
                    begin
                        if (slot_x >= top_x)
                        begin
                            status_next = cfse_pkg::ST_RANGE;
                            exec_err    = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = slot_x[AW-1:0];
                            state_next = cfse_pkg::S_SLOT_WR;
                        end
                    end
                    cfse_pkg::CMD_FETCH:
                    begin
                        if (src_s[SW-1] || src_s >= top_s || slot_x >= top_x)
                        begin
                            status_next = cfse_pkg::ST_RANGE;
                            exec_err    = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = src_s[AW-1:0];
                            state_next = cfse_pkg::S_SLOT_WR;
                        end
                    end
                    default:
                    begin
                        status_next = cfse_pkg::ST_OK;
                    end
                endcase
            end

            cfse_pkg::S_INV_FP:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(top_reg + TW'(1));
                wr_data    = WW'(fp_reg);
                fp_next    = AW'(top_reg + TW'(1));
                top_next   = top_reg + TW'(2);
                state_next = cfse_pkg::S_FILL;
            end

            cfse_pkg::S_FILL:
            begin
                if (cnt_reg == '0)
                begin
                    calls_next = calls_reg + cfse_pkg::CALLS_W'(1);
                    pc_next    = tgt_reg;
                    state_next = cfse_pkg::S_TOP;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = top_reg[AW-1:0];
                    wr_data  = '0;
                    top_next = top_reg + TW'(1);
                    cnt_next = cnt_reg - cfse_pkg::CNT_W'(1);
                end
            end

            cfse_pkg::S_RET_FP:
            begin
                newfp_next = rd_data[AW-1:0];
                rd_en      = 1'b1;
                rd_addr    = fp_reg - AW'(1);
                state_next = cfse_pkg::S_RET_PC;
            end

            cfse_pkg::S_RET_PC:
            begin
                newpc_next = rd_data[PW-1:0];
                rd_en      = 1'b1;
                rd_addr    = fp_reg + AW'(1);
                state_next = cfse_pkg::S_RET_END;
            end

            cfse_pkg::S_RET_END:
            begin
                wr_en      = 1'b1;
                wr_addr    = fp_reg - AW'(1);
                wr_data    = (top_reg > TW'(fp_reg) + TW'(1)) ? rd_data : {WW{1'b1}};
                top_next   = TW'(fp_reg);
                fp_next    = newfp_reg;
                pc_next    = newpc_reg;
                calls_next = calls_reg - cfse_pkg::CALLS_W'(1);
                state_next = cfse_pkg::S_TOP;
            end

            cfse_pkg::S_COPY_TOP:
            begin
                wr_en      = 1'b1;
                wr_addr    = top_reg[AW-1:0];
                wr_data    = rd_data;
                top_next   = top_reg + TW'(1);
                pc_next    = pc_reg + PW'(1);
                state_next = cfse_pkg::S_TOP;
            end

            cfse_pkg::S_SLOT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_x[AW-1:0];
                wr_data = (cmd_reg == cfse_pkg::CMD_INCR) ? sum_word : rd_data;
                if (cmd_reg == cfse_pkg::CMD_STORE)
                begin
                    top_next = top_reg - TW'(1);
                end
                pc_next    = pc_reg + PW'(1);
                state_next = cfse_pkg::S_TOP;
            end

            cfse_pkg::S_TOP:
            begin
                rd_en      = 1'b1;
                rd_addr    = AW'(top_reg - TW'(1));
                state_next = cfse_pkg::S_OUT;
            end

            cfse_pkg::S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_pc_next     = pc_reg;
                    out_top_next    = (top_reg == '0) ? '0 : rd_data;
                    out_calls_next  = calls_reg;
                    out_status_next = status_reg;
                    state_next      = cfse_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = cfse_pkg::S_IDLE;
            end
        endcase
    end

    `CFSE_ASSERT_SAME(a_top_bound, 1'b1, top_reg <= TW'(cfse_pkg::STACK_DEPTH),
        "stack pointer beyond stack depth")

    `CFSE_ASSERT_NEXT(a_err_hold, state_reg == cfse_pkg::S_EXEC && exec_err,
        $stable(top_reg) && $stable(fp_reg) && $stable(pc_reg) && $stable(calls_reg),
        "flagged command changed machine state")

    `CFSE_ASSERT_SAME(a_frame_below_top,
        state_reg == cfse_pkg::S_IDLE && calls_reg != '0,
        TW'(fp_reg) < top_reg, "frame pointer not below stack top with an active call")

    `CFSE_ASSERT_SAME(a_idle_no_write, state_reg == cfse_pkg::S_IDLE, !wr_en && !rd_en,
        "stack memory accessed while idle")

    `CFSE_ASSERT_NEXT(a_out_load, state_reg == cfse_pkg::S_OUT && (!out_valid_reg || m_tready),
        out_valid_reg && state_reg == cfse_pkg::S_IDLE,
        "result not presented after final step")

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the call-frame stack engine: directed and random command streams against a predictor.
module tb_top;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 1950;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] offset;
        logic [5:0]  var_index;
        logic [5:0]  local_count;
        logic [15:0] target;
        logic [2:0]  command;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  depth;
        logic [31:0] top_word;
        logic [15:0] pc;
    } frame_result_t;

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [cfse_pkg::IN_W-1:0]  s_tdata  = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [cfse_pkg::OUT_W-1:0] m_tdata;

    logic [31:0] stack_words [cfse_pkg::STACK_DEPTH];
    logic [8:0]  model_sp    = '0;
    logic [7:0]  model_fp    = '0;
    logic [15:0] model_pc    = '0;
    logic [7:0]  model_depth = '0;

    frame_result_t pending_results [$];
    int            error_count = 0;
    int            idle_cycles = 0;
    int            burst_left  = 0;
    logic          hold_request = 1'b0;
    logic          hold_taken   = 1'b0;
    int            hold_count   = 0;
    int            mode         = 0;
    int            mode_left    = 0;
    logic [1:0]    tick         = '0;

    call_frame_stack_engine_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic frame_step(input cmd_item_t c, output frame_result_t r);
        cfse_pkg::status_t st;
        logic        advance;
        int          top_i;
        int          fp_i;
        int          slot;
        longint      src_l;
        logic [15:0] ret_pc;
        logic [31:0] word;
        st      = cfse_pkg::ST_OK;
        advance = 1'b0;
        top_i   = int'(model_sp);
        fp_i    = int'(model_fp);
        slot    = fp_i + int'(c.var_index) + 1;
        case (c.command)
            cfse_pkg::CMD_INVOKE:
            begin
                if (c.local_count > cfse_pkg::MAX_LOCALS || model_depth == cfse_pkg::CALLS_MAX ||
                    top_i + 2 + int'(c.local_count) > cfse_pkg::STACK_DEPTH)
                    st = cfse_pkg::ST_OVERFLOW;
                else
                begin
                    ret_pc = model_pc + 16'd1;
                    stack_words[top_i]     = {16'd0, ret_pc};
                    stack_words[top_i + 1] = {24'd0, model_fp};
                    model_fp = 8'(top_i + 1);
                    for (int i = 0; i < int'(c.local_count); i++)
                        stack_words[top_i + 2 + i] = '0;
                    model_sp    = 9'(top_i + 2 + int'(c.local_count));
                    model_depth = model_depth + 8'd1;
                    model_pc    = c.target;
                end
            end
            cfse_pkg::CMD_RETURN:
            begin
                if (model_depth == 0)
                    st = cfse_pkg::ST_NOCALL;
                else if (fp_i == 0 || top_i <= fp_i)
                    st = cfse_pkg::ST_UNDERFLOW;
                else
                begin
                    word = (top_i > fp_i + 1) ? stack_words[fp_i + 1] : 32'hFFFF_FFFF;
                    model_fp = stack_words[fp_i][7:0];
                    model_pc = stack_words[fp_i - 1][15:0];
                    stack_words[fp_i - 1] = word;
                    model_sp    = 9'(fp_i);
                    model_depth = model_depth - 8'd1;
                end
            end
            cfse_pkg::CMD_PUSH:
            begin
                if (top_i >= cfse_pkg::STACK_DEPTH)
                    st = cfse_pkg::ST_OVERFLOW;
                else
                begin
                    stack_words[top_i] = c.value;
                    model_sp = 9'(top_i + 1);
                    advance  = 1'b1;
                end
            end
            cfse_pkg::CMD_LOAD:
            begin
                if (slot >= top_i)
                    st = cfse_pkg::ST_RANGE;
                else if (top_i >= cfse_pkg::STACK_DEPTH)
                    st = cfse_pkg::ST_OVERFLOW;
                else
                begin
                    stack_words[top_i] = stack_words[slot];
                    model_sp = 9'(top_i + 1);
                    advance  = 1'b1;
                end
            end
            cfse_pkg::CMD_STORE:
            begin
                if (top_i == 0)
                    st = cfse_pkg::ST_UNDERFLOW;
                else if (slot >= top_i - 1)
                    st = cfse_pkg::ST_RANGE;
                else
                begin
                    stack_words[slot] = stack_words[top_i - 1];
                    model_sp = 9'(top_i - 1);
                    advance  = 1'b1;
                end
            end
            cfse_pkg::CMD_INCR:
            begin
                if (slot >= top_i)
                    st = cfse_pkg::ST_RANGE;
                else
                begin
                    stack_words[slot] = stack_words[slot] + c.offset;
                    advance = 1'b1;
                end
            end
            cfse_pkg::CMD_FETCH:
            begin
                src_l = longint'(fp_i) + longint'($signed(c.offset));
                if (src_l < 0 || src_l >= longint'(top_i) || slot >= top_i)
                    st = cfse_pkg::ST_RANGE;
                else
                begin
                    stack_words[slot] = stack_words[int'(src_l)];
                    advance = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (advance)
            model_pc = model_pc + 16'd1;
        r.pc       = model_pc;
        r.top_word = (model_sp > 0) ? stack_words[int'(model_sp) - 1] : 32'd0;
        r.depth    = model_depth;
        r.status   = st;
    endtask

    function automatic cmd_item_t make_cmd(logic [2:0] command, logic [15:0] target,
                                           logic [5:0] count, logic [5:0] var_index,
                                           logic [31:0] offset, logic [31:0] value);
        cmd_item_t c;
        c.command     = command;
        c.target      = target;
        c.local_count = count;
        c.var_index   = var_index;
        c.offset      = offset;
        c.value       = value;
        return c;
    endfunction

    task automatic send_command(input cmd_item_t item);
        frame_result_t res;
        int            gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        s_tdata  <= cfse_pkg::IN_W'(item);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        frame_step(item, res);
        pending_results.push_back(res);
    endtask

    task automatic pick_random_command(output cmd_item_t c);
        int pick;
        int live;
        int src;
        int r;
        c.command     = cfse_pkg::CMD_PUSH;
        c.target      = 16'($urandom);
        c.var_index   = 6'($urandom);
        c.offset      = $urandom;
        c.value       = $urandom;
        r = $urandom_range(0, 19);
        if (r < 16)
            c.local_count = 6'($urandom_range(0, 6));
        else if (r < 19)
            c.local_count = 6'($urandom_range(0, 20));
        else
            c.local_count = 6'($urandom_range(0, 63));
        live = int'(model_sp) - int'(model_fp) - 1;
        if (live > 0 && $urandom_range(0, 6) != 0)
            c.var_index = 6'($urandom_range(0, (live > 64) ? 63 : live - 1));
        if ($urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 4))
                0: c.value = 32'h0000_0000;
                1: c.value = 32'h0000_0001;
                2: c.value = 32'hFFFF_FFFF;
                3: c.value = 32'h7FFF_FFFF;
                default: c.value = 32'h8000_0000;
            endcase
        end
        pick = $urandom_range(0, 99);
        if (model_sp > 180 && model_depth > 0 && pick < 50)
            pick = 12;
        if (pick < 12)
            c.command = cfse_pkg::CMD_INVOKE;
        else if (pick < 24)
            c.command = (model_depth == 0 && $urandom_range(0, 9) != 0) ? cfse_pkg::CMD_PUSH
                                                                         : cfse_pkg::CMD_RETURN;
        else if (pick < 40)
            c.command = cfse_pkg::CMD_PUSH;
        else if (pick < 55)
            c.command = cfse_pkg::CMD_LOAD;
        else if (pick < 70)
            c.command = cfse_pkg::CMD_STORE;
        else if (pick < 82)
        begin
            c.command = cfse_pkg::CMD_INCR;
            if ($urandom_range(0, 2) != 0)
                c.offset = 32'($urandom_range(0, 20)) - 32'd10;
        end
        else if (pick < 97)
        begin
            c.command = cfse_pkg::CMD_FETCH;
            if (model_sp > 0 && $urandom_range(0, 4) != 0)
            begin
                src = $urandom_range(0, int'(model_sp) - 1);
                c.offset = 32'(src - int'(model_fp));
            end
            else if ($urandom_range(0, 1) == 0)
                c.offset = ($urandom_range(0, 1) == 0) ? 32'(-int'(model_fp) - 1)
                                                       : 32'(int'(model_sp) - int'(model_fp));
        end
        else
            c.command = ($urandom_range(0, 1) == 0) ? 3'd7 : 3'($urandom);
        if (model_sp > 180 && (c.command == cfse_pkg::CMD_PUSH ||
            c.command == cfse_pkg::CMD_LOAD) && $urandom_range(0, 1) == 0)
            c.command = cfse_pkg::CMD_STORE;
    endtask

    task automatic test_empty_stack();
        send_command(make_cmd(cfse_pkg::CMD_RETURN, 16'h0, 6'd0, 6'd0, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_STORE, 16'h0, 6'd0, 6'd0, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_LOAD, 16'h0, 6'd0, 6'd0, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_FETCH, 16'h0, 6'd0, 6'd0, 32'h0, 32'h0));
        send_command(make_cmd(3'd7, 16'hFFFF, 6'd63, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_frames();
        send_command(make_cmd(cfse_pkg::CMD_PUSH, 16'h0, 6'd0, 6'd0, 32'h0, 32'h8000_0000));
        send_command(make_cmd(cfse_pkg::CMD_INVOKE, 16'hFFFF, 6'd0, 6'd0, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_INVOKE, 16'h1234, 6'd2, 6'd0, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_PUSH, 16'h0, 6'd0, 6'd0, 32'h0, 32'h7FFF_FFFF));
        send_command(make_cmd(cfse_pkg::CMD_STORE, 16'h0, 6'd0, 6'd1, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_LOAD, 16'h0, 6'd0, 6'd1, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_INCR, 16'h0, 6'd0, 6'd1, 32'h0000_0001, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_FETCH, 16'h0, 6'd0, 6'd0, 32'h0000_0002, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_FETCH, 16'h0, 6'd0, 6'd1, 32'hFFFF_FFFC, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_FETCH, 16'h0, 6'd0, 6'd0, 32'h7FFF_FFFF, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_FETCH, 16'h0, 6'd0, 6'd0, 32'h8000_0000, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_RETURN, 16'h0, 6'd0, 6'd0, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_INVOKE, 16'h0042, 6'd0, 6'd0, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_RETURN, 16'h0, 6'd0, 6'd0, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_RETURN, 16'h0, 6'd0, 6'd0, 32'h0, 32'h0));
    endtask

    task automatic test_full_stack();
        repeat (3)
            send_command(make_cmd(cfse_pkg::CMD_INVOKE, 16'h0100, 6'd63, 6'd0, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_INVOKE, 16'h0200,
                              6'(cfse_pkg::STACK_DEPTH - int'(model_sp) - 2),
                              6'd0, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_PUSH, 16'h0, 6'd0, 6'd0, 32'h0, 32'h1));
        send_command(make_cmd(cfse_pkg::CMD_LOAD, 16'h0, 6'd0, 6'd0, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_FETCH, 16'h0, 6'd0, 6'd0, 32'h0000_0001, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_INVOKE, 16'h0300, 6'd0, 6'd0, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_STORE, 16'h0, 6'd0, 6'd63, 32'h0, 32'h0));
        send_command(make_cmd(cfse_pkg::CMD_INCR, 16'h0, 6'd0, 6'd56, 32'h7FFF_FFFF, 32'h0));
    endtask

    task automatic test_backpressure();
        cmd_item_t c;
        hold_request <= 1'b1;
        repeat (24)
        begin
            pick_random_command(c);
            send_command(c);
        end
    endtask

    task automatic test_random_stream();
        cmd_item_t c;
        repeat (RANDOM_ITEMS)
        begin
            pick_random_command(c);
            send_command(c);
        end
    endtask

    task automatic check_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            error_count = error_count + 1;
            if (error_count <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        frame_result_t exp_r;
        frame_result_t act_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            act_r = m_tdata[$bits(frame_result_t)-1:0];
            if (pending_results.size() == 0)
            begin
                error_count = error_count + 1;
                if (error_count <= PRINT_CAP)
                    $display("%0t: unexpected transfer, expected none, actual %h", $time, act_r);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("program_counter", 32'(exp_r.pc), 32'(act_r.pc));
                check_field("top_value", exp_r.top_word, act_r.top_word);
                check_field("call_depth_out", 32'(exp_r.depth), 32'(act_r.depth));
                check_field("status", 32'(exp_r.status), 32'(act_r.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_count <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (hold_count > 0)
        begin
            hold_count <= hold_count - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode      <= $urandom_range(0, 2);
                mode_left <= $urandom_range(16, 200);
            end
            else
                mode_left <= mode_left - 1;
            tick <= tick + 2'd1;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (tick == 2'd0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_stack();
        test_frames();
        test_full_stack();
        test_backpressure();
        test_random_stream();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
